@@ hw/rtl/rspa_pkg.sv @@
// Shared types, codes and control store of the slot pair allocator.
package rspa_pkg;

  localparam int unsigned SUM_W = 11;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_CLAIM = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ID   = 2'd1;
  localparam logic [1:0] ST_BAD_PICK = 2'd2;

  localparam logic [1:0] REG_FIRST_BASE   = 2'd0;
  localparam logic [1:0] REG_FIRST_COUNT  = 2'd1;
  localparam logic [1:0] REG_SECOND_BASE  = 2'd2;
  localparam logic [1:0] REG_SECOND_COUNT = 2'd3;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pair_id;
    logic [7:0]  first_pick;
    logic [7:0]  second_pick;
  } in_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic [1:0]  status;
  } out_t;

  typedef logic [4:0] pc_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LATCH,
    OP_CHECK,
    OP_SET_F,
    OP_SET_S,
    OP_MOD_ID,
    OP_MOD_BASE,
    OP_SAVE_BM,
    OP_READ_MOD,
    OP_WR_BUMP,
    OP_INIT_F,
    OP_INIT_S,
    OP_TEST,
    OP_FOUND,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_CLR_MORE,
    C_NO_START,
    C_ALLOC,
    C_RESV,
    C_BAD,
    C_MOD_BUSY,
    C_NO_SECOND,
    C_MISS,
    C_FZERO,
    C_ALLOC_END
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } uword_t;

  typedef struct packed {
    logic clr_more;
    logic start;
    logic alloc;
    logic resv;
    logic bad;
    logic mod_busy;
    logic no_second;
    logic miss;
    logic fzero;
    logic alloc_end;
  } flags_t;

  localparam pc_t PC_CLR     = 5'd0;
  localparam pc_t PC_IDLE    = 5'd1;
  localparam pc_t PC_F_WAIT  = 5'd7;
  localparam pc_t PC_S_WAIT  = 5'd12;
  localparam pc_t PC_ALLOC   = 5'd15;
  localparam pc_t PC_SCAN    = 5'd16;
  localparam pc_t PC_BM_WAIT = 5'd17;
  localparam pc_t PC_ID_WAIT = 5'd20;
  localparam pc_t PC_TEST    = 5'd22;
  localparam pc_t PC_DONE    = 5'd25;

  localparam uword_t UCODE [0:31] = '{
    '{OP_CLEAR,    C_CLR_MORE,  PC_CLR},
    '{OP_LATCH,    C_NO_START,  PC_IDLE},
    '{OP_NOP,      C_ALLOC,     PC_ALLOC},
    '{OP_NOP,      C_RESV,      PC_DONE},
    '{OP_CHECK,    C_BAD,       PC_DONE},
    '{OP_SET_F,    C_NEVER,     PC_IDLE},
    '{OP_MOD_ID,   C_NEVER,     PC_IDLE},
    '{OP_NOP,      C_MOD_BUSY,  PC_F_WAIT},
    '{OP_READ_MOD, C_NEVER,     PC_IDLE},
    '{OP_WR_BUMP,  C_NO_SECOND, PC_DONE},
    '{OP_SET_S,    C_NEVER,     PC_IDLE},
    '{OP_MOD_ID,   C_NEVER,     PC_IDLE},
    '{OP_NOP,      C_MOD_BUSY,  PC_S_WAIT},
    '{OP_READ_MOD, C_NEVER,     PC_IDLE},
    '{OP_WR_BUMP,  C_ALWAYS,    PC_DONE},
    '{OP_INIT_F,   C_FZERO,     PC_DONE},
    '{OP_MOD_BASE, C_NEVER,     PC_IDLE},
    '{OP_NOP,      C_MOD_BUSY,  PC_BM_WAIT},
    '{OP_SAVE_BM,  C_NEVER,     PC_IDLE},
    '{OP_MOD_ID,   C_NEVER,     PC_IDLE},
    '{OP_NOP,      C_MOD_BUSY,  PC_ID_WAIT},
    '{OP_READ_MOD, C_NEVER,     PC_IDLE},
    '{OP_TEST,     C_MISS,      PC_TEST},
    '{OP_FOUND,    C_ALLOC_END, PC_DONE},
    '{OP_INIT_S,   C_ALWAYS,    PC_SCAN},
    '{OP_EMIT,     C_ALWAYS,    PC_IDLE},
    '{OP_NOP,      C_ALWAYS,    PC_IDLE},
    '{OP_NOP,      C_ALWAYS,    PC_IDLE},
    '{OP_NOP,      C_ALWAYS,    PC_IDLE},
    '{OP_NOP,      C_ALWAYS,    PC_IDLE},
    '{OP_NOP,      C_ALWAYS,    PC_IDLE},
    '{OP_NOP,      C_ALWAYS,    PC_IDLE}
  };

endpackage

@@ hw/rtl/rspa_ram.sv @@
// Use count table: one write port, one registered read port.
module rspa_ram #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  assign rd_data = rd_r;

endmodule

@@ hw/rtl/rspa_mod.sv @@
// Reduction of a table offset modulo the table depth by reciprocal multiplication.
module rspa_mod #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [rspa_pkg::SUM_W-1:0] a,
  output logic                       busy,
  output logic [AW-1:0]              res
);

  localparam int unsigned SH = rspa_pkg::SUM_W + AW;
  localparam longint unsigned RECIP = ((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
  localparam int unsigned MW = $clog2(RECIP + 64'd1);
  localparam int unsigned PW = rspa_pkg::SUM_W + MW;
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic [rspa_pkg::SUM_W-1:0] a_r, a_nxt;
  logic [rspa_pkg::SUM_W-1:0] q_r, q_nxt;
  logic [AW-1:0]              res_r, res_nxt;
  logic                       mul_r, mul_nxt;
  logic                       sub_r, sub_nxt;
  logic [PW-1:0]              prod;
  logic [rspa_pkg::SUM_W-1:0] qd;

  always_comb begin
    a_nxt   = a_r;
    q_nxt   = q_r;
    res_nxt = res_r;
    mul_nxt = go;
    sub_nxt = mul_r;
    prod    = PW'(a_r) * PW'(RECIP_C);
    qd      = rspa_pkg::SUM_W'(32'(q_r) * DEPTH);
    if (go) begin
      a_nxt = a;
    end
    if (mul_r) begin
      q_nxt = rspa_pkg::SUM_W'(prod >> SH);
    end
    if (sub_r) begin
      res_nxt = AW'(a_r - qd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r <= 1'b0;
      sub_r <= 1'b0;
    end else begin
      mul_r <= mul_nxt;
      sub_r <= sub_nxt;
    end
    a_r   <= a_nxt;
    q_r   <= q_nxt;
    res_r <= res_nxt;
  end

  assign busy = mul_r || sub_r;
  assign res  = res_r;

endmodule

@@ hw/rtl/rspa_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module rspa_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  rspa_pkg::flags_t flags,
  output rspa_pkg::uword_t cw,
  output logic             idle
);

  rspa_pkg::pc_t pc_r, pc_nxt;
  logic          take;

  always_comb begin
    cw = rspa_pkg::UCODE[pc_r];
  end

  always_comb begin
    case (cw.cond)
      rspa_pkg::C_NEVER:     take = 1'b0;
      rspa_pkg::C_ALWAYS:    take = 1'b1;
      rspa_pkg::C_CLR_MORE:  take = flags.clr_more;
      rspa_pkg::C_NO_START:  take = !flags.start;
      rspa_pkg::C_ALLOC:     take = flags.alloc;
      rspa_pkg::C_RESV:      take = flags.resv;
      rspa_pkg::C_BAD:       take = flags.bad;
      rspa_pkg::C_MOD_BUSY:  take = flags.mod_busy;
      rspa_pkg::C_NO_SECOND: take = flags.no_second;
      rspa_pkg::C_MISS:      take = flags.miss;
      rspa_pkg::C_FZERO:     take = flags.fzero;
      rspa_pkg::C_ALLOC_END: take = flags.alloc_end;
      default:               take = 1'b0;
    endcase
    pc_nxt = take ? cw.tgt : pc_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rspa_pkg::PC_CLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign idle = (pc_r == rspa_pkg::PC_IDLE);

endmodule

@@ hw/rtl/refcounted_slot_pair_allocator_top.sv @@
// Slot pair allocator top level: config registers, datapath and count table.
//
// After reset the block clears its TABLE_DEPTH use counts, one entry a cycle, with busy
// high; configuration writes are taken throughout. An item is taken when start is high
// and busy low; its single result word appears on out_data for one cycle with out_valid,
// and must be taken then, since the receiver cannot stall. Busy stays high while a free or
// claim updates its first range count and, with a second range, its second range count.
// A bad free or claim id, the reserved mode or an empty first range go straight to the
// result. Allocate sets up each range with two modulo reductions, of the range base and of
// the start position, then tests one table entry per cycle until it finds a free entry or
// has tested every entry of the range; the single table read port sets the scan rate.
module refcounted_slot_pair_allocator_top #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rspa_pkg::in_t  in_data,
  output logic           out_valid,
  output rspa_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [9:0]     cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [9:0] first_base_r, second_base_r;
  logic [7:0] first_count_r, second_count_r;

  rspa_pkg::in_t  in_r, in_nxt;
  rspa_pkg::out_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    res_r, res_nxt;
  logic [1:0]     st_r, st_nxt;
  logic           rsel_r, rsel_nxt;
  logic [7:0]     id_r, id_nxt;
  logic [7:0]     i_r, i_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  bm_r, bm_nxt;
  logic [AW-1:0]  clr_r, clr_nxt;

  rspa_pkg::uword_t cw;
  rspa_pkg::flags_t flags;
  logic             idle;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [7:0]                 ram_wdata, rdat;
  logic                       mod_go, mod_busy;
  logic [rspa_pkg::SUM_W-1:0] mod_a, sum_id;
  logic [AW-1:0]              mod_res;

  logic [9:0]    cur_base;
  logic [7:0]    cur_count;
  logic [7:0]    fid, sid;
  logic          bad, hit, wrap_id;
  logic [7:0]    inc_v, dec_v, adv_id;
  logic [AW-1:0] adv_idx;

  function automatic logic [7:0] start_id(logic [7:0] pick, logic [7:0] cnt);
    logic [7:0] p;
    logic [8:0] s;
    p = (pick >= cnt) ? 8'd0 : pick;
    s = {1'b0, p} + 9'd1;
    start_id = (s == {1'b0, cnt}) ? 8'd1 : 8'(s + 9'd1);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_base_r   <= 10'd0;
      first_count_r  <= 8'd1;
      second_base_r  <= 10'd0;
      second_count_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rspa_pkg::REG_FIRST_BASE:   first_base_r   <= cfg_data;
        rspa_pkg::REG_FIRST_COUNT:  first_count_r  <= cfg_data[7:0];
        rspa_pkg::REG_SECOND_BASE:  second_base_r  <= cfg_data;
        rspa_pkg::REG_SECOND_COUNT: second_count_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cur_base  = rsel_r ? second_base_r : first_base_r;
  assign cur_count = rsel_r ? second_count_r : first_count_r;
  assign sum_id    = rspa_pkg::SUM_W'(cur_base) + rspa_pkg::SUM_W'(id_r)
                     - rspa_pkg::SUM_W'(1);

  assign fid = in_r.pair_id[15:8];
  assign sid = in_r.pair_id[7:0];
  assign bad = (fid == 8'd0) || (fid > first_count_r) ||
               ((second_count_r != 8'd0) && ((sid == 8'd0) || (sid > second_count_r)));

  assign inc_v = (rdat == rspa_pkg::CNT_MAX) ? rdat : rdat + 8'd1;
  assign dec_v = (rdat == 8'd0) ? rdat : rdat - 8'd1;

  assign hit     = (rdat == 8'd0) || (i_r == cur_count - 8'd1);
  assign wrap_id = (id_r == cur_count);
  assign adv_id  = wrap_id ? 8'd1 : id_r + 8'd1;
  assign adv_idx = wrap_id ? bm_r :
                   ((idx_r == AW'(TABLE_DEPTH - 1)) ? '0 : idx_r + AW'(1));

  always_comb begin
    flags.clr_more  = (clr_r != AW'(TABLE_DEPTH - 1));
    flags.start     = start;
    flags.alloc     = (in_r.mode == rspa_pkg::MODE_ALLOC);
    flags.resv      = (in_r.mode == rspa_pkg::MODE_RSVD);
    flags.bad       = bad;
    flags.mod_busy  = mod_busy;
    flags.no_second = (second_count_r == 8'd0);
    flags.miss      = !hit;
    flags.fzero     = (first_count_r == 8'd0);
    flags.alloc_end = rsel_r || (second_count_r == 8'd0);
  end

  always_comb begin
    in_nxt        = in_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    st_nxt        = st_r;
    rsel_nxt      = rsel_r;
    id_nxt        = id_r;
    i_nxt         = i_r;
    idx_nxt       = idx_r;
    bm_nxt        = bm_r;
    clr_nxt       = clr_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = inc_v;
    ram_re        = 1'b0;
    ram_raddr     = mod_res;
    mod_go        = 1'b0;
    mod_a         = sum_id;
    case (cw.op)
      rspa_pkg::OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 8'd0;
        clr_nxt   = clr_r + AW'(1);
      end
      rspa_pkg::OP_LATCH: begin
        if (start) begin
          in_nxt  = in_data;
          res_nxt = in_data.pair_id;
          st_nxt  = rspa_pkg::ST_OK;
        end
      end
      rspa_pkg::OP_CHECK: begin
        if (bad) begin
          st_nxt = rspa_pkg::ST_BAD_ID;
        end
      end
      rspa_pkg::OP_SET_F: begin
        rsel_nxt = 1'b0;
        id_nxt   = fid;
      end
      rspa_pkg::OP_SET_S: begin
        rsel_nxt = 1'b1;
        id_nxt   = sid;
      end
      rspa_pkg::OP_MOD_ID: begin
        mod_go = 1'b1;
      end
      rspa_pkg::OP_MOD_BASE: begin
        mod_go = 1'b1;
        mod_a  = rspa_pkg::SUM_W'(cur_base);
      end
      rspa_pkg::OP_SAVE_BM: begin
        bm_nxt = mod_res;
      end
      rspa_pkg::OP_READ_MOD: begin
        ram_re  = 1'b1;
        idx_nxt = mod_res;
      end
      rspa_pkg::OP_WR_BUMP: begin
        ram_we    = 1'b1;
        ram_wdata = (in_r.mode == rspa_pkg::MODE_CLAIM) ? inc_v : dec_v;
      end
      rspa_pkg::OP_INIT_F: begin
        rsel_nxt = 1'b0;
        i_nxt    = 8'd0;
        if (first_count_r == 8'd0) begin
          res_nxt = 16'd0;
          st_nxt  = rspa_pkg::ST_BAD_ID;
        end else begin
          id_nxt = start_id(in_r.first_pick, first_count_r);
          if (in_r.first_pick >= first_count_r) begin
            st_nxt = rspa_pkg::ST_BAD_PICK;
          end
        end
      end
      rspa_pkg::OP_INIT_S: begin
        rsel_nxt = 1'b1;
        i_nxt    = 8'd0;
        id_nxt   = start_id(in_r.second_pick, second_count_r);
        if (in_r.second_pick >= second_count_r) begin
          st_nxt = rspa_pkg::ST_BAD_PICK;
        end
      end
      rspa_pkg::OP_TEST: begin
        if (!hit) begin
          ram_re    = 1'b1;
          ram_raddr = adv_idx;
          idx_nxt   = adv_idx;
          id_nxt    = adv_id;
          i_nxt     = i_r + 8'd1;
        end
      end
      rspa_pkg::OP_FOUND: begin
        ram_we = 1'b1;
        if (!rsel_r) begin
          res_nxt = {id_r, inc_v};
        end else begin
          res_nxt[7:0] = id_r;
        end
      end
      rspa_pkg::OP_EMIT: begin
        out_valid_nxt    = 1'b1;
        out_nxt.result_id = res_r;
        out_nxt.status    = st_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
    end
    in_r   <= in_nxt;
    out_r  <= out_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
    rsel_r <= rsel_nxt;
    id_r   <= id_nxt;
    i_r    <= i_nxt;
    idx_r  <= idx_nxt;
    bm_r   <= bm_nxt;
  end

  rspa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw),
    .idle  (idle)
  );

  rspa_mod #(
    .DEPTH (TABLE_DEPTH)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mod_go),
    .a     (mod_a),
    .busy  (mod_busy),
    .res   (mod_res)
  );

  rspa_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rd_data (rdat)
  );

  assign busy      = !idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result word shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_mod_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mod_go |-> !mod_busy)
    else $error("modulo unit restarted while busy");

  a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table read and write in the same cycle");

  a_scan_id: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == rspa_pkg::OP_TEST) |-> (id_r != 8'd0 && id_r <= cur_count))
    else $error("scan id outside its range");
`endif

endmodule
